@@ src/lcts_pkg.sv @@
// Shared types, constants and saturating helpers for the logic channel timing statistics unit.
// No dependencies; every other file in src refers to this package by scoped names.
`timescale 1ns / 1ps

package lcts_pkg;

  localparam int CHANNELS   = 8;
  localparam int COUNT_BITS = 32;
  localparam int SAMPLE_W   = 8;
  localparam int FIELD_W    = 32;
  localparam int OUT_CH_W   = 3;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RES_BITS   = OUT_CH_W + 9 * FIELD_W;
  localparam int OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;
  localparam int PAD_W      = OUT_DATA_W - RES_BITS;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t CMAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    cnt_t high_cnt;
    cnt_t edge_cnt;
    cnt_t rise_cnt;
    cnt_t first_rise;
    cnt_t last_rise;
    cnt_t period_sum;
    cnt_t open_rise;
    logic open_rise_ok;
    logic open_fall_ok;
    cnt_t pend_high;
    cnt_t min_high;
    cnt_t min_low;
    cnt_t last_edge;
    logic last_edge_ok;
  } lane_t;

  typedef struct packed {
    logic busy;
    logic free;
  } merge_stat_t;

  function automatic cnt_t sat_inc(input cnt_t x);
    return (x == CMAX) ? x : x + cnt_t'(1);
  endfunction

  function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? CMAX : s[COUNT_BITS-1:0];
  endfunction

endpackage

@@ src/lcts_lane.sv @@
// One channel lane: edge, run-width and period tracking for a single sample bit.
// Depends on lcts_pkg for the lane state type and saturating helpers.
`timescale 1ns / 1ps

module lcts_lane (
  input  logic                clk,
  input  logic                upd,
  input  logic                restart,
  input  logic                lvl,
  input  logic                prev_lvl,
  input  lcts_pkg::cnt_t      idx,
  output lcts_pkg::lane_t     st_next
);

  lcts_pkg::lane_t st;
  lcts_pkg::cnt_t  w;

  assign w = idx - st.last_edge;

  always_comb begin
    st_next = st;
    if (restart) begin
      st_next              = '0;
      st_next.min_high     = lcts_pkg::CMAX;
      st_next.min_low      = lcts_pkg::CMAX;
      st_next.high_cnt     = lvl ? lcts_pkg::cnt_t'(1) : '0;
    end else begin
      if (lvl != prev_lvl) begin
        st_next.edge_cnt     = lcts_pkg::sat_inc(st.edge_cnt);
        if (st.last_edge_ok) begin
          if (lvl && (w < st.min_low)) st_next.min_low = w;
          if (!lvl && (w < st.min_high)) st_next.min_high = w;
        end
        st_next.last_edge    = idx;
        st_next.last_edge_ok = 1'b1;
        if (lvl) begin
          st_next.rise_cnt = lcts_pkg::sat_inc(st.rise_cnt);
          if (st.rise_cnt == '0) st_next.first_rise = idx;
          if (st.open_rise_ok && st.open_fall_ok)
            st_next.period_sum = lcts_pkg::sat_add(st.period_sum, st.pend_high);
          st_next.open_rise    = idx;
          st_next.open_rise_ok = 1'b1;
          st_next.open_fall_ok = 1'b0;
          st_next.last_rise    = idx;
        end else if (st.open_rise_ok && !st.open_fall_ok) begin
          st_next.pend_high    = idx - st.open_rise;
          st_next.open_fall_ok = 1'b1;
        end
      end
      if (lvl) st_next.high_cnt = lcts_pkg::sat_inc(st.high_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (upd) st <= st_next;
  end

endmodule

@@ src/lcts_merge.sv @@
// Result merge: snapshots all lanes at window end and serialises one result per channel.
// Depends on lcts_pkg for the lane state, status struct and output layout constants.
`timescale 1ns / 1ps

module lcts_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          capture,
  input  lcts_pkg::cnt_t                cap_pos,
  input  lcts_pkg::lane_t               lane_next [lcts_pkg::CHANNELS],
  output lcts_pkg::merge_stat_t         stat,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // channel, edges, rising_edges, high_samples, min_high, min_low,
  // first_rise, last_rise, high_in_periods, window_len, zero pad
  output logic [lcts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // valid_res
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);

  lcts_pkg::lane_t              snap [lcts_pkg::CHANNELS];
  lcts_pkg::cnt_t               snap_pos;
  logic                         snap_valid;
  logic [lcts_pkg::CH_W-1:0]    rd_ch;
  logic                         out_valid;
  logic [lcts_pkg::OUT_DATA_W-1:0] out_data;
  logic                         out_user;
  logic                         out_last;
  logic                         load;
  logic                         free;
  logic                         is_short;
  lcts_pkg::lane_t              sel;
  logic [lcts_pkg::FIELD_W-1:0] f_edges, f_rise, f_high, f_minh, f_minl;
  logic [lcts_pkg::FIELD_W-1:0] f_first, f_last, f_per, f_len;

  assign load = snap_valid && (!out_valid || m_axis_tready);
  assign free = load && (rd_ch == lcts_pkg::CH_W'(lcts_pkg::CHANNELS - 1));
  assign stat.busy = snap_valid;
  assign stat.free = free;

  assign sel      = snap[rd_ch];
  assign is_short = snap_pos < lcts_pkg::cnt_t'(2);

  always_comb begin
    f_edges = '0;
    f_rise  = '0;
    f_high  = '0;
    f_minh  = '0;
    f_minl  = '0;
    f_first = '0;
    f_last  = '0;
    f_per   = '0;
    f_len   = '0;
    if (!is_short) begin
      f_edges = lcts_pkg::FIELD_W'(sel.edge_cnt);
      f_rise  = lcts_pkg::FIELD_W'(sel.rise_cnt);
      f_high  = lcts_pkg::FIELD_W'(sel.high_cnt);
      f_minh  = (sel.min_high != lcts_pkg::CMAX) ? lcts_pkg::FIELD_W'(sel.min_high) : '0;
      f_minl  = (sel.min_low != lcts_pkg::CMAX) ? lcts_pkg::FIELD_W'(sel.min_low) : '0;
      f_first = (sel.rise_cnt != '0) ? lcts_pkg::FIELD_W'(sel.first_rise) : '0;
      f_last  = (sel.rise_cnt != '0) ? lcts_pkg::FIELD_W'(sel.last_rise) : '0;
      f_per   = lcts_pkg::FIELD_W'(sel.period_sum);
      f_len   = lcts_pkg::FIELD_W'(snap_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
      rd_ch      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (capture) begin
        snap_valid <= 1'b1;
        rd_ch      <= '0;
      end else if (free) begin
        snap_valid <= 1'b0;
        rd_ch      <= '0;
      end else if (load) begin
        rd_ch <= rd_ch + lcts_pkg::CH_W'(1);
      end
      if (load) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      snap     <= lane_next;
      snap_pos <= cap_pos;
    end
    if (load) begin
      out_data <= {{lcts_pkg::PAD_W{1'b0}}, f_len, f_per, f_last, f_first, f_minl, f_minh,
                   f_high, f_rise, f_edges, lcts_pkg::OUT_CH_W'(rd_ch)};
      out_user <= !is_short && (sel.edge_cnt != '0);
      out_last <= free;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  a_capture_room: assert property (@(posedge clk) disable iff (rst)
    capture |-> (!snap_valid || free))
    else $error("snapshot overwritten before drained");

  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_data[lcts_pkg::OUT_CH_W-1:0] ==
                                lcts_pkg::OUT_CH_W'(lcts_pkg::CHANNELS - 1))))
    else $error("last flag not on final channel");

  a_hold_snap: assert property (@(posedge clk) disable iff (rst)
    (load && !free && !capture) |=> snap_valid)
    else $error("snapshot dropped mid-drain");

  a_free_clears: assert property (@(posedge clk) disable iff (rst)
    (free && !capture) |=> (!snap_valid && rd_ch == '0))
    else $error("snapshot not released after final channel");
`endif

endmodule

@@ src/logic_channel_timing_stats_unit.sv @@
// Output: a window-end request is snapshotted at acceptance; the output register then
// sends one result per cycle while m_axis_tready allows, CHANNELS in total.
// Throughput: one sample per cycle unless stalled; the eight lanes update in parallel.
// A window-end request waits only while the previous window's results still occupy the
// snapshot (windows shorter than CHANNELS samples or a stalled output).
// Reset: synchronous; closes the window and empties the snapshot and output register.
`timescale 1ns / 1ps

module logic_channel_timing_stats_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // sample
  input  logic [lcts_pkg::SAMPLE_W-1:0]    s_axis_tdata,
  // window_start
  input  logic                             s_axis_tuser,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // channel, edges, rising_edges, high_samples, min_high, min_low,
  // first_rise, last_rise, high_in_periods, window_len, zero pad
  output logic [lcts_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // valid_res
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);

  lcts_pkg::cnt_t                   position;
  lcts_pkg::cnt_t                   position_next;
  logic [lcts_pkg::CHANNELS-1:0]    prev_sample;
  logic [lcts_pkg::CHANNELS-1:0]    cur;
  logic                             accept;
  logic                             restart;
  lcts_pkg::merge_stat_t            mstat;
  lcts_pkg::lane_t                  lane_next [lcts_pkg::CHANNELS];

  assign s_axis_tready = !(s_axis_tlast && mstat.busy && !mstat.free);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign restart       = s_axis_tuser || (position == '0);
  assign cur           = s_axis_tdata[lcts_pkg::CHANNELS-1:0];
  assign position_next = restart ? lcts_pkg::cnt_t'(1) : lcts_pkg::sat_inc(position);

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept) begin
      position <= s_axis_tlast ? '0 : position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) prev_sample <= cur;
  end

  for (genvar g = 0; g < lcts_pkg::CHANNELS; g++) begin : g_lane
    lcts_lane u_lane (
      .clk      (clk),
      .upd      (accept),
      .restart  (restart),
      .lvl      (cur[g]),
      .prev_lvl (prev_sample[g]),
      .idx      (position),
      .st_next  (lane_next[g])
    );
  end

  lcts_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .capture       (accept && s_axis_tlast),
    .cap_pos       (position_next),
    .lane_next     (lane_next),
    .stat          (mstat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
